>>> sv/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

    localparam int LEN_W   = 63;
    localparam int INDEX_W = 32;

    // Result kinds.
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Fragmentation classes.
    localparam logic [2:0] CLASS_OPEN     = 3'd0;
    localparam logic [2:0] CLASS_MIDDLE   = 3'd1;
    localparam logic [2:0] CLASS_CLOSING  = 3'd2;
    localparam logic [2:0] CLASS_CONTROL  = 3'd3;
    localparam logic [2:0] CLASS_DATA     = 3'd4;
    localparam logic [2:0] CLASS_REJECTED = 3'd5;

    // Header codes.
    localparam logic [3:0] OPC_CONTINUATION = 4'h0;
    localparam logic [6:0] LEN_CODE_16      = 7'd126;
    localparam logic [6:0] LEN_CODE_64      = 7'd127;

    typedef struct packed {
        logic               kind;
        logic [7:0]         raw_byte;
        logic [7:0]         key_byte;
        logic               fin;
        logic [2:0]         rsv;
        logic [3:0]         opcode;
        logic               masked;
        logic [LEN_W-1:0]   length;
        logic [2:0]         msg_class;
        logic [INDEX_W-1:0] frag_index;
        logic               last;
    } wsd_item_t;

endpackage

`default_nettype wire

>>> sv/wsd_parser.sv
// Front end: parses the frame header, classifies the frame and queues one request per result.
`default_nettype none

module wsd_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        stream_byte,
    output logic                   emit,
    output wsd_pkg::wsd_item_t     item
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    logic [2:0]         phase_reg, phase_next;
    logic [2:0]         count_reg, count_next;
    logic [7:0]         flags_reg, flags_next;
    logic               masked_reg, masked_next;
    logic               long_reg, long_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic [31:0]        key_reg, key_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [1:0]         pos_reg, pos_next;
    logic               active_reg, active_next;
    logic [INDEX_W-1:0] counter_reg, counter_next;
    logic [2:0]         class_reg, class_next;
    logic [INDEX_W-1:0] index_reg, index_next;

    logic       hdr_done;
    logic       is_cont;
    logic       is_ctrl;
    logic       is_data;
    logic       res_kind;
    logic       res_last;
    logic [7:0] res_key;

    assign is_cont = (flags_reg[3:0] == OPC_CONTINUATION);
    assign is_ctrl = flags_reg[3];
    assign is_data = !is_cont && !is_ctrl;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        flags_next   = flags_reg;
        masked_next  = masked_reg;
        long_next    = long_reg;
        length_next  = length_reg;
        key_next     = key_reg;
        remain_next  = remain_reg;
        pos_next     = pos_reg;
        active_next  = active_reg;
        counter_next = counter_reg;
        class_next   = class_reg;
        index_next   = index_reg;
        hdr_done     = 1'b0;
        emit         = 1'b0;
        res_kind     = KIND_HEADER;
        res_last     = 1'b0;
        res_key      = 8'h00;

        if (accept)
        begin
            case (phase_reg)
                PH_BYTE1:
                begin
                    masked_next = stream_byte[7];
                    key_next    = 32'h0;
                    count_next  = 3'd0;
                    if (stream_byte[6:0] == LEN_CODE_16 || stream_byte[6:0] == LEN_CODE_64)
                    begin
                        long_next   = (stream_byte[6:0] == LEN_CODE_64);
                        length_next = '0;
                        phase_next  = PH_EXTLEN;
                    end
                    else
                    begin
                        length_next = {{(LEN_W-7){1'b0}}, stream_byte[6:0]};
                        if (stream_byte[7])
                            phase_next = PH_MASK;
                        else
                            hdr_done = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    // Shifting inside 63 bits drops the top bit of a 64-bit length.
                    length_next = {length_reg[LEN_W-9:0], stream_byte};
                    count_next  = count_reg + 3'd1;
                    if (count_reg == (long_reg ? EXT64_LAST : EXT16_LAST))
                    begin
                        count_next = 3'd0;
                        if (masked_reg)
                            phase_next = PH_MASK;
                        else
                            hdr_done = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    key_next   = {key_reg[23:0], stream_byte};
                    count_next = count_reg + 3'd1;
                    if (count_reg == KEY_LAST)
                    begin
                        count_next = 3'd0;
                        hdr_done   = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    case (pos_reg)
                        2'd0:    res_key = key_reg[31:24];
                        2'd1:    res_key = key_reg[23:16];
                        2'd2:    res_key = key_reg[15:8];
                        default: res_key = key_reg[7:0];
                    endcase
                    pos_next    = pos_reg + 2'd1;
                    remain_next = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    res_last    = (remain_reg == {{(LEN_W-1){1'b0}}, 1'b1});
                    res_kind    = KIND_PAYLOAD;
                    emit        = 1'b1;
                    if (res_last)
                        phase_next = PH_BYTE0;
                end
                default:
                begin
                    flags_next = stream_byte;
                    phase_next = PH_BYTE1;
                end
            endcase
        end

        if (hdr_done)
        begin
            index_next = '0;
            if (!active_reg && !flags_reg[7] && is_data)
            begin
                active_next  = 1'b1;
                counter_next = counter_reg + {{(INDEX_W-1){1'b0}}, 1'b1};
                index_next   = counter_next;
                class_next   = CLASS_OPEN;
            end
            else if (active_reg && is_cont)
            begin
                index_next  = counter_reg;
                class_next  = flags_reg[7] ? CLASS_CLOSING : CLASS_MIDDLE;
                active_next = !flags_reg[7];
            end
            else if (!active_reg && flags_reg[7] && !is_cont)
            begin
                class_next = is_ctrl ? CLASS_CONTROL : CLASS_DATA;
            end
            else
            begin
                class_next = CLASS_REJECTED;
            end
            remain_next = length_next;
            pos_next    = 2'd0;
            res_last    = (length_next == '0);
            phase_next  = res_last ? PH_BYTE0 : PH_PAYLOAD;
            emit        = 1'b1;
        end
    end

    always_comb
    begin
        item.kind       = res_kind;
        item.raw_byte   = stream_byte;
        item.key_byte   = res_key;
        item.fin        = flags_reg[7];
        item.rsv        = flags_reg[6:4];
        item.opcode     = flags_reg[3:0];
        item.masked     = masked_next;
        item.length     = length_next;
        item.msg_class  = class_next;
        item.frag_index = index_next;
        item.last       = res_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BYTE0;
            count_reg   <= 3'd0;
            flags_reg   <= 8'h00;
            masked_reg  <= 1'b0;
            long_reg    <= 1'b0;
            length_reg  <= '0;
            key_reg     <= 32'h0;
            remain_reg  <= '0;
            pos_reg     <= 2'd0;
            active_reg  <= 1'b0;
            counter_reg <= '0;
            class_reg   <= CLASS_OPEN;
            index_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            flags_reg   <= flags_next;
            masked_reg  <= masked_next;
            long_reg    <= long_next;
            length_reg  <= length_next;
            key_reg     <= key_next;
            remain_reg  <= remain_next;
            pos_reg     <= pos_next;
            active_reg  <= active_next;
            counter_reg <= counter_next;
            class_reg   <= class_next;
            index_reg   <= index_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The payload phase is only ever entered with bytes left to deliver.
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with no bytes remaining");

    // A header with a nonzero length must be followed by the payload phase.
    a_header_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
        emit && item.kind == KIND_HEADER && !item.last |=> phase_reg == PH_PAYLOAD)
        else $error("header result not followed by payload phase");
`endif

endmodule

`default_nettype wire

>>> sv/wsd_queue.sv
// Short request queue between the header parser and the output stage.
`default_nettype none

module wsd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wsd_pkg::wsd_item_t      push_item,
    output logic                    full,
    input  wire logic               pop,
    output wsd_pkg::wsd_item_t      head_item,
    output logic                    empty
);
    import wsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsd_item_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // A request offered to a full queue would be dropped.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("request pushed into a full queue");
`endif

endmodule

`default_nettype wire

>>> sv/wsd_unmask.sv
// Back end: unmasks payload bytes and holds the result register on the output side.
`default_nettype none

module wsd_unmask (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wsd_pkg::wsd_item_t     q_item,
    output logic                   q_pop,
    input  wire logic              pop,
    output logic                   empty,
    output wsd_pkg::wsd_item_t     out_item
);
    import wsd_pkg::*;

    logic      valid_reg, valid_next;
    wsd_item_t data_reg;
    wsd_item_t data_next;

    assign q_pop = !q_empty && (!valid_reg || pop);

    always_comb
    begin
        data_next          = q_item;
        data_next.raw_byte = (q_item.kind == KIND_PAYLOAD) ?
                             (q_item.raw_byte ^ q_item.key_byte) : 8'h00;
        data_next.key_byte = 8'h00;
        valid_next         = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign empty    = !valid_reg;
    assign out_item = data_reg;

endmodule

`default_nettype wire

>>> sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: parser, request queue and output stage.
// Path: a result enters the queue at the edge that accepts the byte completing it, then
// moves into the output register when that register is empty or being popped.
// Throughput: one byte per cycle while full is low; full rises only while the queue is
// full behind an unpopped output register, which a pop refills from a nonempty queue.
// Reset: rst_n clears parser state, fragment tracking, the queue and the output register.
`default_nettype none

module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    stream_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               item_kind,
    output logic [7:0]                         payload_byte,
    output logic                               final_flag,
    output logic [2:0]                         reserved_bits,
    output logic [3:0]                         frame_opcode,
    output logic                               is_masked,
    output logic [wsd_pkg::LEN_W-1:0]          payload_length,
    output logic [2:0]                         message_class,
    output logic [wsd_pkg::INDEX_W-1:0]        fragment_index,
    output logic                               last_of_frame
);
    import wsd_pkg::*;

    logic      accept;
    logic      emit;
    wsd_item_t parsed;
    logic      q_empty;
    logic      q_pop;
    wsd_item_t q_head;
    wsd_item_t result;

    assign accept = push && !full;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .emit        (emit),
        .item        (parsed)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_item (parsed),
        .full      (full),
        .pop       (q_pop),
        .head_item (q_head),
        .empty     (q_empty)
    );

    wsd_unmask u_unmask (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (result)
    );

    assign item_kind      = result.kind;
    assign payload_byte   = result.raw_byte;
    assign final_flag     = result.fin;
    assign reserved_bits  = result.rsv;
    assign frame_opcode   = result.opcode;
    assign is_masked      = result.masked;
    assign payload_length = result.length;
    assign message_class  = result.msg_class;
    assign fragment_index = result.frag_index;
    assign last_of_frame  = result.last;

endmodule

`default_nettype wire
